>>> design/fdsp_pkg.sv
package fdsp_pkg;

	typedef enum logic [1:0] {
		ACT_ACQUIRE   = 2'd0,
		ACT_FREE      = 2'd1,
		ACT_FRAME_END = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_GRANTED    = 3'd0,
		STAT_RELEASED   = 3'd1,
		STAT_DEFERRED   = 3'd2,
		STAT_FRAME_DONE = 3'd3,
		STAT_POOL_FULL  = 3'd4,
		STAT_INVALID    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SLOT_AVAIL     = 2'd0,
		SLOT_ACQ       = 2'd1,
		SLOT_WAIT_END  = 2'd2,
		SLOT_WAIT_FREE = 2'd3
	} slot_st_t;

endpackage

>>> design/fdsp_ram.sv
module fdsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/frame_deferred_slot_pool_core.sv
// Deferred-release slot pool over a ring of POOL_SIZE slots.
// Command channel: an item (action, slot, release_tag) is taken on a rising
// edge with start high and busy low; busy stays high while it is worked on.
// Result channel: result_valid marks each result for exactly one cycle, with
// status, slot_out, tag_out and last; last is high on the final result of an
// item. The receiver cannot stall, so results are never held back.
// Config: cfg_we with cfg_wdata writes tracking_enabled; write only when idle.
// Steps: one slot state is examined per cycle through a single read port,
// except in the tag read step of a frame end.
//   acquire   : scans from the ring pointer to an available slot, or pool full.
//   free      : checks the given slot and gives its result.
//   frame end : walks from frame start to ring pointer, with a tag memory
//               read step per release; tracking off: result, busy stays low.
// Each result appears in the cycle after the step that produces it; an item
// that gives no result (action 3) never raises busy.
// Reset: all slots available, ring pointer and frame start 0, tracking off.
// Tag memory is not cleared; only tags written by a free are ever read.
module frame_deferred_slot_pool_core #(
	parameter int POOL_SIZE = 16,
	parameter int TAG_BITS  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [3:0] slot,
	input  logic [7:0] release_tag,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output logic       result_valid,
	output logic [2:0] status,
	output logic [3:0] slot_out,
	output logic [7:0] tag_out,
	output logic       last
);

	import fdsp_pkg::*;

	localparam int IW = $clog2(POOL_SIZE);
	localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

	typedef enum logic [4:0] {
		FSM_IDLE = 5'b00001,
		FSM_SCAN = 5'b00010,
		FSM_FREE = 5'b00100,
		FSM_WALK = 5'b01000,
		FSM_TAG  = 5'b10000
	} fsm_t;

	fsm_t            fsm_q, fsm_d;
	logic [IW-1:0]   idx_q, idx_d, nxt_idx;
	logic [IW-1:0]   cnt_q, cnt_d;
	logic [IW-1:0]   rp_q, rp_d;
	logic [IW-1:0]   fs_q, fs_d;
	logic            track_q;
	slot_st_t        slot_state_q [POOL_SIZE];
	slot_st_t        cur_st, st_wdata;
	logic            st_we;

	logic [3:0]          slot_in_q;
	logic                slot_ok_q;
	logic [TAG_BITS-1:0] tag_in_q;

	logic                ram_we;
	logic [TAG_BITS-1:0] ram_rdata;

	logic       emit;
	status_t    status_d, status_q;
	logic [3:0] slot_out_d, slot_out_q;
	logic [7:0] tag_out_d, tag_out_q;
	logic       last_d, last_q;
	logic       res_vld_q;

	logic        accept;
	logic [31:0] slot_ext, rel_ext, tag_in_ext, rdata_ext, idx_ext;

	assign accept     = start && !busy;
	assign slot_ext   = 32'(slot);
	assign rel_ext    = 32'(release_tag);
	assign tag_in_ext = 32'(tag_in_q);
	assign rdata_ext  = 32'(ram_rdata);
	assign idx_ext    = 32'(idx_q);
	assign cur_st     = slot_state_q[idx_q];
	assign nxt_idx    = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	always_comb begin
		fsm_d      = fsm_q;
		idx_d      = idx_q;
		cnt_d      = cnt_q;
		rp_d       = rp_q;
		fs_d       = fs_q;
		st_we      = 1'b0;
		st_wdata   = SLOT_AVAIL;
		ram_we     = 1'b0;
		emit       = 1'b0;
		status_d   = STAT_FRAME_DONE;
		slot_out_d = '0;
		tag_out_d  = '0;
		last_d     = 1'b1;
		case (fsm_q)
			FSM_IDLE: begin
				if (start) begin
					case (action_t'(action))
						ACT_ACQUIRE: begin
							idx_d = rp_q;
							cnt_d = '0;
							fsm_d = FSM_SCAN;
						end
						ACT_FREE: begin
							idx_d = slot_ext[IW-1:0];
							fsm_d = FSM_FREE;
						end
						ACT_FRAME_END: begin
							if (track_q) begin
								idx_d = fs_q;
								fsm_d = FSM_WALK;
							end else begin
								emit = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			FSM_SCAN: begin
				if (cnt_q != '0 && idx_q == fs_q) begin
					emit     = 1'b1;
					status_d = STAT_POOL_FULL;
					fsm_d    = FSM_IDLE;
				end else if (cur_st == SLOT_AVAIL) begin
					st_we      = 1'b1;
					st_wdata   = SLOT_ACQ;
					rp_d       = nxt_idx;
					emit       = 1'b1;
					status_d   = STAT_GRANTED;
					slot_out_d = idx_ext[3:0];
					fsm_d      = FSM_IDLE;
				end else if (cnt_q == LAST_IDX) begin
					emit     = 1'b1;
					status_d = STAT_POOL_FULL;
					fsm_d    = FSM_IDLE;
				end else begin
					idx_d = nxt_idx;
					cnt_d = cnt_q + 1'b1;
				end
			end
			FSM_FREE: begin
				emit       = 1'b1;
				slot_out_d = slot_in_q;
				fsm_d      = FSM_IDLE;
				if (slot_ok_q && cur_st == SLOT_ACQ) begin
					st_we     = 1'b1;
					st_wdata  = SLOT_WAIT_END;
					ram_we    = 1'b1;
					status_d  = STAT_DEFERRED;
					tag_out_d = tag_in_ext[7:0];
				end else if (slot_ok_q && cur_st == SLOT_WAIT_FREE) begin
					st_we     = 1'b1;
					st_wdata  = SLOT_AVAIL;
					status_d  = STAT_RELEASED;
					tag_out_d = tag_in_ext[7:0];
				end else begin
					status_d = STAT_INVALID;
				end
			end
			FSM_WALK: begin
				if (idx_q == rp_q) begin
					emit  = 1'b1;
					fs_d  = rp_q;
					fsm_d = FSM_IDLE;
				end else if (cur_st == SLOT_ACQ) begin
					st_we    = 1'b1;
					st_wdata = SLOT_WAIT_FREE;
					idx_d    = nxt_idx;
				end else if (cur_st == SLOT_WAIT_END) begin
					fsm_d = FSM_TAG;
				end else begin
					idx_d = nxt_idx;
				end
			end
			FSM_TAG: begin
				// tag read issued during the walk step is now valid
				st_we      = 1'b1;
				st_wdata   = SLOT_AVAIL;
				emit       = 1'b1;
				status_d   = STAT_RELEASED;
				slot_out_d = idx_ext[3:0];
				tag_out_d  = rdata_ext[7:0];
				last_d     = 1'b0;
				idx_d      = nxt_idx;
				fsm_d      = FSM_WALK;
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= FSM_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			rp_q      <= '0;
			fs_q      <= '0;
			track_q   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			fsm_q     <= fsm_d;
			idx_q     <= idx_d;
			cnt_q     <= cnt_d;
			rp_q      <= rp_d;
			fs_q      <= fs_d;
			res_vld_q <= emit;
			if (cfg_we) begin
				track_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				slot_state_q[i] <= SLOT_AVAIL;
			end
		end else if (st_we) begin
			slot_state_q[idx_q] <= st_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_in_q <= slot;
			slot_ok_q <= (slot_ext < 32'(POOL_SIZE));
			tag_in_q  <= rel_ext[TAG_BITS-1:0];
		end
		if (emit) begin
			status_q   <= status_d;
			slot_out_q <= slot_out_d;
			tag_out_q  <= tag_out_d;
			last_q     <= last_d;
		end
	end

	fdsp_ram #(
		.WIDTH(TAG_BITS),
		.DEPTH(POOL_SIZE)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(tag_in_q),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign busy         = (fsm_q != FSM_IDLE);
	assign result_valid = res_vld_q;
	assign status       = status_q;
	assign slot_out     = slot_out_q;
	assign tag_out      = tag_out_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_only_release_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> status == STAT_RELEASED)
		else $error("non-final result that is not a release");

	a_last_means_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("final result while still busy");

	a_ignored_action: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_NONE |=> !result_valid && !busy)
		else $error("ignored action produced activity");

	a_work_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == ACT_ACQUIRE || action == ACT_FREE) |=> busy && !result_valid)
		else $error("acquire or free did not enter its work step");
`endif

endmodule

>>> verif/frame_deferred_slot_pool_core_tb.sv
`timescale 1ns / 100ps

module frame_deferred_slot_pool_core_tb;
	import fdsp_pkg::*;

	localparam int POOL_SIZE = 16;
	localparam int DIR_ROWS  = 22;

	typedef struct {
		status_t    st;
		logic [3:0] slot_no;
		logic [7:0] tag;
		logic       last;
	} pool_result_t;

	// directed row: cfg rows carry the tracking value in slot[0]
	typedef struct {
		bit         cfg;
		action_t    act;
		logic [3:0] slot;
		logic [7:0] tag;
		int         reps;
		bit         typed;
		status_t    st;
		logic [3:0] so;
		logic [7:0] to;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] action = 2'd0;
	logic [3:0] slot = 4'd0;
	logic [7:0] release_tag = 8'd0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       busy;
	logic       result_valid;
	logic [2:0] status;
	logic [3:0] slot_out;
	logic [7:0] tag_out;
	logic       last;

	// predicted pool
	slot_st_t     pool_state [POOL_SIZE];
	logic [7:0]   pool_tag [POOL_SIZE];
	logic [3:0]   ring_ptr;
	logic [3:0]   frame_base;
	bit           tracking_en;
	pool_result_t step_results[$];
	pool_result_t pending_results[$];
	int           fail_cnt = 0;

	stim_row_t dir_tab [DIR_ROWS] = '{
		'{0, ACT_FREE,      4'd0,  8'h00, 1, 1, STAT_INVALID,    4'd0,  8'h00},
		'{0, ACT_FRAME_END, 4'd0,  8'h00, 1, 1, STAT_FRAME_DONE, 4'd0,  8'h00},
		'{0, ACT_NONE,      4'd15, 8'hff, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_ACQUIRE,   4'd9,  8'h77, 1, 1, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_ACQUIRE,   4'd0,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FREE,      4'd0,  8'hff, 1, 1, STAT_DEFERRED,   4'd0,  8'hff},
		'{0, ACT_FREE,      4'd0,  8'h12, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{1, ACT_NONE,      4'd1,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FRAME_END, 4'd3,  8'h44, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_ACQUIRE,   4'd0,  8'h00, 13, 0, STAT_GRANTED,   4'd0,  8'h00},
		'{0, ACT_FRAME_END, 4'd0,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_ACQUIRE,   4'd0,  8'h00, 2, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_ACQUIRE,   4'd0,  8'h00, 1, 1, STAT_POOL_FULL,  4'd0,  8'h00},
		'{0, ACT_FREE,      4'd1,  8'ha5, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FREE,      4'd7,  8'h5a, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FREE,      4'd15, 8'h3c, 1, 1, STAT_DEFERRED,   4'd15, 8'h3c},
		'{0, ACT_ACQUIRE,   4'd0,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FRAME_END, 4'd0,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FREE,      4'd15, 8'hc3, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{1, ACT_NONE,      4'd0,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00},
		'{0, ACT_FRAME_END, 4'd0,  8'h00, 1, 1, STAT_FRAME_DONE, 4'd0,  8'h00},
		'{1, ACT_NONE,      4'd1,  8'h00, 1, 0, STAT_GRANTED,    4'd0,  8'h00}
	};

	int phase_len [5] = '{150, 40, 150, 30, 130};
	bit phase_trk [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

	frame_deferred_slot_pool_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.slot         (slot),
		.release_tag  (release_tag),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.status       (status),
		.slot_out     (slot_out),
		.tag_out      (tag_out),
		.last         (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// one item through the predicted pool, results into step_results
	function automatic void pool_step(input action_t a, input logic [3:0] s,
			input logic [7:0] t);
		logic [3:0] p;
		bit         granted;
		step_results.delete();
		case (a)
			ACT_ACQUIRE: begin
				p = ring_ptr;
				granted = 1'b0;
				for (int n = 0; n < POOL_SIZE; n++) begin
					if (n > 0 && p == frame_base)
						break;
					if (pool_state[p] == SLOT_AVAIL) begin
						pool_state[p] = SLOT_ACQ;
						ring_ptr = p + 4'd1;
						step_results.push_back('{STAT_GRANTED, p, 8'h00, 1'b1});
						granted = 1'b1;
						break;
					end
					p = p + 4'd1;
				end
				if (!granted)
					step_results.push_back('{STAT_POOL_FULL, 4'd0, 8'h00, 1'b1});
			end
			ACT_FREE: begin
				if (pool_state[s] == SLOT_ACQ) begin
					pool_state[s] = SLOT_WAIT_END;
					pool_tag[s] = t;
					step_results.push_back('{STAT_DEFERRED, s, t, 1'b1});
				end else if (pool_state[s] == SLOT_WAIT_FREE) begin
					pool_state[s] = SLOT_AVAIL;
					step_results.push_back('{STAT_RELEASED, s, t, 1'b1});
				end else begin
					step_results.push_back('{STAT_INVALID, s, 8'h00, 1'b1});
				end
			end
			ACT_FRAME_END: begin
				if (tracking_en) begin
					p = frame_base;
					while (p != ring_ptr) begin
						if (pool_state[p] == SLOT_ACQ) begin
							pool_state[p] = SLOT_WAIT_FREE;
						end else if (pool_state[p] == SLOT_WAIT_END) begin
							pool_state[p] = SLOT_AVAIL;
							step_results.push_back('{STAT_RELEASED, p, pool_tag[p], 1'b0});
						end
						p = p + 4'd1;
					end
					frame_base = ring_ptr;
				end
				step_results.push_back('{STAT_FRAME_DONE, 4'd0, 8'h00, 1'b1});
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input action_t a, input logic [3:0] s, input logic [7:0] t,
			input bit typed, input pool_result_t want);
		start <= 1'b1;
		action <= a;
		slot <= s;
		release_tag <= t;
		do @(posedge clk); while (busy);
		pool_step(a, s, t);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (step_results[i])
				pending_results.push_back(step_results[i]);
	endtask

	task automatic gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_tracking(input bit v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracking_en = v;
	endtask

	always @(posedge clk) begin
		pool_result_t exp_r;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d slot %0d tag %0h",
					status, slot_out, tag_out);
				fail_cnt++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status: expected %0d, got %0d", exp_r.st, status);
					fail_cnt++;
				end
				if (slot_out !== exp_r.slot_no) begin
					$error("slot_out: expected %0d, got %0d", exp_r.slot_no, slot_out);
					fail_cnt++;
				end
				if (tag_out !== exp_r.tag) begin
					$error("tag_out: expected %0h, got %0h", exp_r.tag, tag_out);
					fail_cnt++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		pool_result_t want;
		action_t      a;
		logic [3:0]   s;
		int           cnt;
		int           item_no;
		int           r;
		int           held;
		int           cand[$];

		foreach (pool_state[i]) begin
			pool_state[i] = SLOT_AVAIL;
			pool_tag[i] = 8'h00;
		end
		ring_ptr = 4'd0;
		frame_base = 4'd0;
		tracking_en = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg) begin
				drain();
				write_tracking(dir_tab[i].slot[0]);
			end else begin
				want = '{dir_tab[i].st, dir_tab[i].so, dir_tab[i].to, 1'b1};
				repeat (dir_tab[i].reps)
					send_item(dir_tab[i].act, dir_tab[i].slot, dir_tab[i].tag,
						dir_tab[i].typed, want);
			end
		end

		// random part; acquire is held back when the pool is nearly all in use,
		// otherwise the ring can lock up with every slot taken
		want = '{STAT_GRANTED, 4'd0, 8'h00, 1'b0};
		item_no = 0;
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_tracking(phase_trk[ph]);
			cnt = 0;
			while (cnt < phase_len[ph]) begin
				if (!(item_no >= 150 && item_no < 300) && $urandom_range(99) < 6)
					gap($urandom_range(1, 6));
				held = 0;
				cand.delete();
				foreach (pool_state[i]) begin
					if (pool_state[i] != SLOT_AVAIL)
						held++;
					if (pool_state[i] == SLOT_ACQ || pool_state[i] == SLOT_WAIT_FREE)
						cand.push_back(i);
				end
				s = 4'($urandom_range(15));
				r = $urandom_range(99);
				if (r < 4)
					a = ACT_NONE;
				else if (r < 40 && held <= 13)
					a = ACT_ACQUIRE;
				else if (r < 80) begin
					a = ACT_FREE;
					if (cand.size() != 0 && $urandom_range(9) < 8)
						s = 4'(cand[$urandom_range(cand.size() - 1)]);
				end else
					a = ACT_FRAME_END;
				send_item(a, s, 8'($urandom_range(255)), 1'b0, want);
				if (a != ACT_NONE)
					cnt++;
				item_no++;
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
